// File: design/tqw_pkg.sv
package tqw_pkg;

    localparam int QUEUE_DEPTH = 64;

    // storage geometry
    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W  = $clog2(QUEUE_DEPTH * 255 + 1);

    // field widths
    localparam int KIND_W   = 2;
    localparam int SIZE_W   = 8;
    localparam int TICKET_W = 16;
    localparam int STATUS_W = 3;
    localparam int GCOUNT_W = 7;
    localparam int MCOUNT_W = 14;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_JOIN     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SERVE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WITHDRAW = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP      = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

    localparam logic [TICKET_W-1:0] TICKET_FIRST = 16'd1;
    localparam logic [TICKET_W-1:0] TICKET_LAST  = 16'hFFFF;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SIZE_W-1:0]   group_size;
        logic [TICKET_W-1:0] ticket;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TICKET_W-1:0] result_ticket;
        logic [GCOUNT_W-1:0] group_count;
        logic [MCOUNT_W-1:0] member_count;
    } rsp_item_t;

    typedef struct packed {
        logic [TICKET_W-1:0] ticket;
        logic [SIZE_W-1:0]   size;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // circular pointer step with wrap at any depth
    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
        return (p == '0) ? ADDR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

endpackage

// File: design/tqw_ram.sv
module tqw_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/ticket_queue_with_withdrawal_core.sv
// channel | signals                    | direction | contents
// --------+----------------------------+-----------+------------------------------------
// req     | req_valid, req_ready, req  | in        | kind, group_size, ticket
// rsp     | rsp_valid, rsp_ready, rsp  | out       | status, result_ticket, counts
//
// sequencing: no-op, full, empty and first join finish straight from idle, join and serve
//   pass through S_JOIN or S_SERVE, withdraw scans from the head to the match and then
//   shifts each entry behind it toward the head, one entry ram read and one write per cycle
// reset: rst_n clears pointers, counts and control; the entry ram is not cleared
// stalls: a finished item waits in the rsp register; a following item is taken while
//   it waits, and parks its result in S_RESP until the register frees up

module ticket_queue_with_withdrawal_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  tqw_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output tqw_pkg::rsp_item_t  rsp
);

    // one-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_JOIN  = 6'b000010,
        S_SERVE = 6'b000100,
        S_SCAN  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // queue lives in a circular buffer: head is the oldest entry, tail the next free slot
    logic [tqw_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [tqw_pkg::ADDR_W-1:0] tail_reg, tail_next;
    logic [tqw_pkg::OCC_W-1:0]  occ_reg, occ_next;
    logic [tqw_pkg::TOT_W-1:0]  total_reg, total_next;

    // scan / shift walk: data_ptr is the slot whose data is on the ram output
    logic [tqw_pkg::ADDR_W-1:0] data_ptr_reg, data_ptr_next;
    logic [tqw_pkg::ADDR_W-1:0] hole_reg, hole_next;
    logic [tqw_pkg::ADDR_W-1:0] nxt_ptr;

    // captured request fields
    logic [tqw_pkg::TICKET_W-1:0] want_reg, want_next;
    logic [tqw_pkg::SIZE_W-1:0]   size_reg, size_next;

    // result waiting for the output register
    logic [tqw_pkg::STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [tqw_pkg::TICKET_W-1:0] pend_ticket_reg, pend_ticket_next;

    logic                rsp_valid_reg, rsp_valid_next;
    tqw_pkg::rsp_item_t  rsp_reg, rsp_next;

    // finishing item
    logic                         fin;
    logic [tqw_pkg::STATUS_W-1:0] fin_status;
    logic [tqw_pkg::TICKET_W-1:0] fin_ticket;

    // entry ram
    logic                       ram_wr_en;
    logic [tqw_pkg::ADDR_W-1:0] ram_wr_addr;
    tqw_pkg::entry_t            ram_wr_data;
    logic                       ram_rd_en;
    logic [tqw_pkg::ADDR_W-1:0] ram_rd_addr;
    tqw_pkg::entry_t            ram_rd_data;

    tqw_ram #(
        .DEPTH (tqw_pkg::QUEUE_DEPTH),
        .WIDTH (tqw_pkg::ENTRY_W)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // counts are masked to the field widths, zero-extended when narrower
    function automatic logic [tqw_pkg::GCOUNT_W-1:0] gcount_field(
        input logic [tqw_pkg::OCC_W-1:0] v
    );
        logic [tqw_pkg::OCC_W+tqw_pkg::GCOUNT_W-1:0] w;
        w = {{tqw_pkg::GCOUNT_W{1'b0}}, v};
        return w[tqw_pkg::GCOUNT_W-1:0];
    endfunction

    function automatic logic [tqw_pkg::MCOUNT_W-1:0] mcount_field(
        input logic [tqw_pkg::TOT_W-1:0] v
    );
        logic [tqw_pkg::TOT_W+tqw_pkg::MCOUNT_W-1:0] w;
        w = {{tqw_pkg::MCOUNT_W{1'b0}}, v};
        return w[tqw_pkg::MCOUNT_W-1:0];
    endfunction

    assign nxt_ptr   = tqw_pkg::ptr_inc(data_ptr_reg);
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        occ_next         = occ_reg;
        total_next       = total_reg;
        data_ptr_next    = data_ptr_reg;
        hole_next        = hole_reg;
        want_next        = want_reg;
        size_next        = size_reg;
        pend_status_next = pend_status_reg;
        pend_ticket_next = pend_ticket_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_next         = rsp_reg;

        fin        = 1'b0;
        fin_status = tqw_pkg::ST_OK;
        fin_ticket = '0;

        ram_wr_en   = 1'b0;
        ram_wr_addr = tail_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    want_next = req.ticket;
                    size_next = req.group_size;
                    case (req.kind)
                        tqw_pkg::KIND_JOIN:
                        begin
                            if (occ_reg == tqw_pkg::OCC_W'(tqw_pkg::QUEUE_DEPTH))
                            begin
                                fin        = 1'b1;
                                fin_status = tqw_pkg::ST_FULL;
                            end
                            else if (occ_reg == '0)
                            begin
                                // empty queue always restarts numbering
                                ram_wr_en          = 1'b1;
                                ram_wr_addr        = tail_reg;
                                ram_wr_data.ticket = tqw_pkg::TICKET_FIRST;
                                ram_wr_data.size   = req.group_size;
                                tail_next          = tqw_pkg::ptr_inc(tail_reg);
                                occ_next           = occ_reg + 1'b1;
                                total_next         = total_reg
                                                   + tqw_pkg::TOT_W'(req.group_size);
                                fin                = 1'b1;
                                fin_ticket         = tqw_pkg::TICKET_FIRST;
                            end
                            else
                            begin
                                // fetch the tail entry's ticket
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = tqw_pkg::ptr_dec(tail_reg);
                                state_next  = S_JOIN;
                            end
                        end
                        tqw_pkg::KIND_SERVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = tqw_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = head_reg;
                                state_next  = S_SERVE;
                            end
                        end
                        tqw_pkg::KIND_WITHDRAW:
                        begin
                            if (occ_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = tqw_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                ram_rd_en     = 1'b1;
                                ram_rd_addr   = head_reg;
                                data_ptr_next = head_reg;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // no-op kind
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_JOIN:
            begin
                if (ram_rd_data.ticket == tqw_pkg::TICKET_LAST)
                begin
                    fin        = 1'b1;
                    fin_status = tqw_pkg::ST_EXHAUSTED;
                end
                else
                begin
                    ram_wr_en          = 1'b1;
                    ram_wr_addr        = tail_reg;
                    ram_wr_data.ticket = ram_rd_data.ticket + 1'b1;
                    ram_wr_data.size   = size_reg;
                    tail_next          = tqw_pkg::ptr_inc(tail_reg);
                    occ_next           = occ_reg + 1'b1;
                    total_next         = total_reg + tqw_pkg::TOT_W'(size_reg);
                    fin                = 1'b1;
                    fin_ticket         = ram_rd_data.ticket + 1'b1;
                end
            end

            S_SERVE:
            begin
                head_next  = tqw_pkg::ptr_inc(head_reg);
                occ_next   = occ_reg - 1'b1;
                total_next = total_reg - tqw_pkg::TOT_W'(ram_rd_data.size);
                fin        = 1'b1;
                fin_ticket = ram_rd_data.ticket;
            end

            S_SCAN:
            begin
                // compare the slot on the ram output while fetching the next one
                ram_rd_en   = 1'b1;
                ram_rd_addr = nxt_ptr;
                if (ram_rd_data.ticket == want_reg)
                begin
                    total_next = total_reg - tqw_pkg::TOT_W'(ram_rd_data.size);
                    if (nxt_ptr == tail_reg)
                    begin
                        // match is the last entry: just pull the tail back
                        tail_next  = data_ptr_reg;
                        occ_next   = occ_reg - 1'b1;
                        fin        = 1'b1;
                        fin_ticket = want_reg;
                    end
                    else
                    begin
                        hole_next     = data_ptr_reg;
                        data_ptr_next = nxt_ptr;
                        state_next    = S_SHIFT;
                    end
                end
                else if (nxt_ptr == tail_reg)
                begin
                    fin        = 1'b1;
                    fin_status = tqw_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    data_ptr_next = nxt_ptr;
                end
            end

            S_SHIFT:
            begin
                // move one entry toward the head per cycle, closing the gap
                ram_wr_en   = 1'b1;
                ram_wr_addr = hole_reg;
                ram_wr_data = ram_rd_data;
                hole_next   = data_ptr_reg;
                if (nxt_ptr == tail_reg)
                begin
                    tail_next  = data_ptr_reg;
                    occ_next   = occ_reg - 1'b1;
                    fin        = 1'b1;
                    fin_ticket = want_reg;
                end
                else
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = nxt_ptr;
                    data_ptr_next = nxt_ptr;
                end
            end

            S_RESP:
            begin
                fin        = 1'b1;
                fin_status = pend_status_reg;
                fin_ticket = pend_ticket_reg;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand the result to the output register or park it
        if (fin)
        begin
            if (!rsp_valid_reg || rsp_ready)
            begin
                rsp_valid_next         = 1'b1;
                rsp_next.status        = fin_status;
                rsp_next.result_ticket = fin_ticket;
                rsp_next.group_count   = gcount_field(occ_next);
                rsp_next.member_count  = mcount_field(total_next);
                state_next             = S_IDLE;
            end
            else
            begin
                pend_status_next = fin_status;
                pend_ticket_next = fin_ticket;
                state_next       = S_RESP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_ptr_reg    <= data_ptr_next;
        hole_reg        <= hole_next;
        want_reg        <= want_next;
        size_reg        <= size_next;
        pend_status_reg <= pend_status_next;
        pend_ticket_reg <= pend_ticket_next;
        rsp_reg         <= rsp_next;
    end

    // occupancy never exceeds the buffer
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= tqw_pkg::OCC_W'(tqw_pkg::QUEUE_DEPTH))
        else $error("occupancy above depth");

    // pointers meet whenever the queue is empty or full
    a_ptr_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != tail_reg) |->
        (occ_reg != '0 && occ_reg != tqw_pkg::OCC_W'(tqw_pkg::QUEUE_DEPTH)))
        else $error("head/tail out of step with occupancy");

    // an empty queue holds no members
    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> (total_reg == '0))
        else $error("member total left over on empty queue");

    // shift never reads the slot it writes
    a_ram_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("entry ram read and write at the same slot");

    // failures carry no ticket
    a_fail_ticket: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != tqw_pkg::ST_OK) |-> (rsp.result_ticket == '0))
        else $error("ticket reported on failed item");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    // one directed row: the item, and where the result is obvious, the exact response
    typedef struct packed {
        tqw_pkg::req_item_t item;
        logic               literal;
        tqw_pkg::rsp_item_t outcome;
    } step_row_t;

    // directed walk from reset: boundaries, every kind, error codes, tail handling
    localparam step_row_t DIRECTED_ROWS [22] = '{
        // nothing waiting: serve and withdraw fail, no-op reports zeros
        '{'{tqw_pkg::KIND_SERVE,    8'hFF, 16'hFFFF}, 1'b1,
          '{tqw_pkg::ST_EMPTY,     16'd0, 7'd0, 14'd0}},
        '{'{tqw_pkg::KIND_WITHDRAW, 8'h00, 16'h0000}, 1'b1,
          '{tqw_pkg::ST_NOT_FOUND, 16'd0, 7'd0, 14'd0}},
        '{'{tqw_pkg::KIND_WITHDRAW, 8'hFF, 16'hFFFF}, 1'b1,
          '{tqw_pkg::ST_NOT_FOUND, 16'd0, 7'd0, 14'd0}},
        '{'{tqw_pkg::KIND_NOP,      8'hFF, 16'hFFFF}, 1'b1,
          '{tqw_pkg::ST_OK,        16'd0, 7'd0, 14'd0}},
        // empty group still gets ticket 1, largest group follows
        '{'{tqw_pkg::KIND_JOIN,     8'h00, 16'h0000}, 1'b1,
          '{tqw_pkg::ST_OK,        16'd1, 7'd1, 14'd0}},
        '{'{tqw_pkg::KIND_JOIN,     8'hFF, 16'hFFFF}, 1'b1,
          '{tqw_pkg::ST_OK,        16'd2, 7'd2, 14'd255}},
        '{'{tqw_pkg::KIND_JOIN,     8'h01, 16'h0000}, 1'b0, '0},
        // ticket zero and the top ticket are never present here
        '{'{tqw_pkg::KIND_WITHDRAW, 8'h00, 16'h0000}, 1'b1,
          '{tqw_pkg::ST_NOT_FOUND, 16'd0, 7'd3, 14'd256}},
        '{'{tqw_pkg::KIND_WITHDRAW, 8'hFF, 16'hFFFF}, 1'b1,
          '{tqw_pkg::ST_NOT_FOUND, 16'd0, 7'd3, 14'd256}},
        // middle then tail withdrawal, next join must follow the new tail
        '{'{tqw_pkg::KIND_WITHDRAW, 8'h00, 16'd2},    1'b0, '0},
        '{'{tqw_pkg::KIND_WITHDRAW, 8'h00, 16'd3},    1'b0, '0},
        '{'{tqw_pkg::KIND_JOIN,     8'h80, 16'h0000}, 1'b0, '0},
        '{'{tqw_pkg::KIND_NOP,      8'h00, 16'h0000}, 1'b0, '0},
        '{'{tqw_pkg::KIND_SERVE,    8'h00, 16'h0000}, 1'b0, '0},
        '{'{tqw_pkg::KIND_WITHDRAW, 8'h00, 16'd2},    1'b0, '0},
        // emptied queue restarts at ticket 1
        '{'{tqw_pkg::KIND_JOIN,     8'h07, 16'h0000}, 1'b1,
          '{tqw_pkg::ST_OK,        16'd1, 7'd1, 14'd7}},
        '{'{tqw_pkg::KIND_WITHDRAW, 8'h00, 16'd1},    1'b0, '0},
        '{'{tqw_pkg::KIND_SERVE,    8'h00, 16'h0000}, 1'b1,
          '{tqw_pkg::ST_EMPTY,     16'd0, 7'd0, 14'd0}},
        // alternating bit patterns on the ignored fields
        '{'{tqw_pkg::KIND_JOIN,     8'hAA, 16'h5555}, 1'b0, '0},
        '{'{tqw_pkg::KIND_JOIN,     8'h55, 16'hAAAA}, 1'b0, '0},
        '{'{tqw_pkg::KIND_SERVE,    8'h33, 16'hCCCC}, 1'b0, '0},
        '{'{tqw_pkg::KIND_SERVE,    8'hCC, 16'h3333}, 1'b0, '0}
    };

    localparam int RANDOM_PER_PHASE = 325;
    localparam int BIAS_SPAN        = 120;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    tqw_pkg::req_item_t req       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    tqw_pkg::rsp_item_t rsp;

    // shadow of the waiting line, head at index 0
    logic [tqw_pkg::TICKET_W-1:0] waiting_tickets [$];
    logic [tqw_pkg::SIZE_W-1:0]   waiting_sizes [$];
    int unsigned                  waiting_members = 0;
    int unsigned                  deepest_line    = 0;

    // responses owed by the block, oldest first
    tqw_pkg::rsp_item_t pending_outcomes [$];
    tqw_pkg::rsp_item_t seen_rsp;
    tqw_pkg::rsp_item_t wanted_rsp;

    int error_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int status_seen [8];

    // idling knobs, percent of cycles
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;

    int phase_idle  [4] = '{0, 74, 0, 28};
    int phase_stall [4] = '{0, 0, 74, 28};

    ticket_queue_with_withdrawal_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver back-pressure, one draw per cycle
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // advance the shadow line by one item and return the response it owes
    function automatic tqw_pkg::rsp_item_t line_step(input tqw_pkg::req_item_t it);
        tqw_pkg::rsp_item_t r;
        int unsigned        next_tk;
        int                 pos;
        r = '0;
        r.status = tqw_pkg::ST_OK;
        case (it.kind)
            tqw_pkg::KIND_JOIN:
            begin
                if (waiting_tickets.size() >= tqw_pkg::QUEUE_DEPTH)
                    r.status = tqw_pkg::ST_FULL;
                else
                begin
                    next_tk = (waiting_tickets.size() == 0)
                            ? 32'(tqw_pkg::TICKET_FIRST)
                            : 32'(waiting_tickets[$]) + 1;
                    // no wrap past the top ticket
                    if (next_tk > 32'(tqw_pkg::TICKET_LAST))
                        r.status = tqw_pkg::ST_EXHAUSTED;
                    else
                    begin
                        waiting_tickets.push_back(tqw_pkg::TICKET_W'(next_tk));
                        waiting_sizes.push_back(it.group_size);
                        waiting_members += it.group_size;
                        r.result_ticket = tqw_pkg::TICKET_W'(next_tk);
                    end
                end
            end
            tqw_pkg::KIND_SERVE:
            begin
                if (waiting_tickets.size() == 0)
                    r.status = tqw_pkg::ST_EMPTY;
                else
                begin
                    r.result_ticket = waiting_tickets.pop_front();
                    waiting_members -= waiting_sizes.pop_front();
                end
            end
            tqw_pkg::KIND_WITHDRAW:
            begin
                // first match from the head wins
                pos = -1;
                for (int i = 0; i < waiting_tickets.size() && pos < 0; i++)
                    if (waiting_tickets[i] == it.ticket)
                        pos = i;
                if (pos < 0)
                    r.status = tqw_pkg::ST_NOT_FOUND;
                else
                begin
                    r.result_ticket = it.ticket;
                    waiting_members -= waiting_sizes[pos];
                    waiting_tickets.delete(pos);
                    waiting_sizes.delete(pos);
                end
            end
            default:
            begin
                // no-op leaves everything alone
            end
        endcase
        if (waiting_tickets.size() > deepest_line)
            deepest_line = waiting_tickets.size();
        r.group_count  = tqw_pkg::GCOUNT_W'(waiting_tickets.size());
        r.member_count = tqw_pkg::MCOUNT_W'(waiting_members);
        return r;
    endfunction

    function automatic tqw_pkg::req_item_t make_req(
        input logic [tqw_pkg::KIND_W-1:0]   kind,
        input logic [tqw_pkg::SIZE_W-1:0]   size,
        input logic [tqw_pkg::TICKET_W-1:0] tk
    );
        tqw_pkg::req_item_t it;
        it.kind       = kind;
        it.group_size = size;
        it.ticket     = tk;
        return it;
    endfunction

    // random item; join_pct steers the line toward full or toward empty
    function automatic tqw_pkg::req_item_t random_req(input int join_pct);
        tqw_pkg::req_item_t it;
        int                 roll;
        int                 pick;
        it = make_req(tqw_pkg::KIND_NOP, tqw_pkg::SIZE_W'($urandom),
                      tqw_pkg::TICKET_W'($urandom));
        roll = $urandom_range(99);
        if (roll < join_pct)
            it.kind = tqw_pkg::KIND_JOIN;
        else if (roll < join_pct + (95 - join_pct) / 2)
            it.kind = tqw_pkg::KIND_SERVE;
        else if (roll < 95)
            it.kind = tqw_pkg::KIND_WITHDRAW;
        // group size extremes show up often
        pick = $urandom_range(9);
        if (pick == 0)
            it.group_size = '0;
        else if (pick == 1)
            it.group_size = '1;
        if (it.kind == tqw_pkg::KIND_WITHDRAW)
        begin
            // mostly a ticket that is really waiting, anywhere in the line
            if (waiting_tickets.size() > 0 && $urandom_range(99) < 80)
                it.ticket = waiting_tickets[$urandom_range(waiting_tickets.size() - 1)];
            else
            begin
                pick = $urandom_range(3);
                if (pick == 0)
                    it.ticket = '0;
                else if (pick == 1)
                    it.ticket = (waiting_tickets.size() == 0) ? tqw_pkg::TICKET_FIRST
                                                              : waiting_tickets[$] + 1'b1;
            end
        end
        return it;
    endfunction

    // offer one item, hold it until taken, then book what it owes
    task automatic push_req(input tqw_pkg::req_item_t it, input logic literal,
                            input tqw_pkg::rsp_item_t outcome);
        tqw_pkg::rsp_item_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = line_step(it);
        pending_outcomes.push_back(literal ? outcome : predicted);
        items_sent++;
    endtask

    // drop the last item so it is not taken twice, then wait for all owed responses
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_outcomes.size() != 0);
    endtask

    function automatic int field_check(input string field, input int unsigned wanted,
                                       input int unsigned seen);
        if (wanted == seen)
            return 0;
        $display("%0t mismatch %s expected %0d actual %0d", $time, field, wanted, seen);
        return 1;
    endfunction

    // response side: every accepted item is checked against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            seen_rsp = rsp;
            results_seen++;
            status_seen[seen_rsp.status]++;
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t unexpected response status %0d ticket %0d", $time,
                         seen_rsp.status, seen_rsp.result_ticket);
                error_count++;
            end
            else
            begin
                wanted_rsp = pending_outcomes.pop_front();
                error_count += field_check("status", 32'(wanted_rsp.status),
                                           32'(seen_rsp.status));
                error_count += field_check("result_ticket", 32'(wanted_rsp.result_ticket),
                                           32'(seen_rsp.result_ticket));
                error_count += field_check("group_count", 32'(wanted_rsp.group_count),
                                           32'(seen_rsp.group_count));
                error_count += field_check("member_count", 32'(wanted_rsp.member_count),
                                           32'(seen_rsp.member_count));
            end
        end
    end

    // stimulus
    initial
    begin
        int join_pct;
        int step;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows, no idling
        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            push_req(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].literal,
                     DIRECTED_ROWS[i].outcome);
        wait_drained();

        // fill to depth with largest groups, overflow, reopen a slot mid-line
        for (int i = 0; i < tqw_pkg::QUEUE_DEPTH; i++)
            push_req(make_req(tqw_pkg::KIND_JOIN, '1, '0), 1'b0, '0);
        push_req(make_req(tqw_pkg::KIND_JOIN, '1, '0), 1'b0, '0);
        push_req(make_req(tqw_pkg::KIND_WITHDRAW, '0,
                          waiting_tickets[tqw_pkg::QUEUE_DEPTH / 2]), 1'b0, '0);
        push_req(make_req(tqw_pkg::KIND_JOIN, 8'd1, '0), 1'b0, '0);
        push_req(make_req(tqw_pkg::KIND_JOIN, 8'd1, '0), 1'b0, '0);
        // drain from both ends
        step = 0;
        while (waiting_tickets.size() > 0)
        begin
            if (step % 2 == 0)
                push_req(make_req(tqw_pkg::KIND_SERVE, '0, '0), 1'b0, '0);
            else
                push_req(make_req(tqw_pkg::KIND_WITHDRAW, '0, waiting_tickets[$]),
                         1'b0, '0);
            step++;
        end
        wait_drained();

        // random phases, each with its own idling mix; bias swings between fill and drain
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = phase_idle[p];
            rsp_stall_pct = phase_stall[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                join_pct = ((n / BIAS_SPAN) % 2 == 0) ? 80 : 15;
                push_req(random_req(join_pct), 1'b0, '0);
            end
            wait_drained();
        end

        rsp_stall_pct = 0;
        wait_drained();
        // long enough for a withdraw across a full line to surface
        repeat (100) @(posedge clk);

        $display("covered %0d items, %0d responses, deepest line %0d groups",
                 items_sent, results_seen, deepest_line);
        $display("status mix ok %0d empty %0d absent %0d full %0d exhausted %0d",
                 status_seen[tqw_pkg::ST_OK], status_seen[tqw_pkg::ST_EMPTY],
                 status_seen[tqw_pkg::ST_NOT_FOUND], status_seen[tqw_pkg::ST_FULL],
                 status_seen[tqw_pkg::ST_EXHAUSTED]);
        if (error_count == 0 && pending_outcomes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog: about 1450 items, some of them withdraws across a full line,
    // plus idling and stalls, stay far below this
    initial
    begin
        #60_000_000;
        $display("%0t timeout with %0d responses outstanding", $time,
                 pending_outcomes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: ticket_queue_with_withdrawal_core.f
design/tqw_pkg.sv
design/tqw_ram.sv
design/ticket_queue_with_withdrawal_core.sv
verif/tb.sv
